// ===== design/qph_pkg.sv =====
// ----------------------------------------------------------------------------
// qph_pkg: shared types and constants for the quadratic probe hash multimap
// Holds field widths, operation/status/mark codes, controller states and the
// command and status groups passed between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package qph_pkg;

  localparam int KEY_W          = 32;
  localparam int VALUE_W        = 32;
  localparam int STATUS_W       = 3;
  localparam int ENTRY_COUNT_W  = 7;
  localparam int MARK_W         = 2;
  localparam int CAPACITY_DEF   = 64;
  // Home slot reduction consumes this many key bits per cycle.
  localparam int MOD_BITS       = 8;
  localparam int MOD_STEPS      = KEY_W / MOD_BITS;
  localparam int MOD_CNT_W      = $clog2(MOD_STEPS);

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    RES_ADDED    = 3'd0,
    RES_PRESENT  = 3'd1,
    RES_REMOVED  = 3'd2,
    RES_NOTFOUND = 3'd3,
    RES_FULL     = 3'd4
  } status_t;

  typedef enum logic [MARK_W-1:0] {
    MARK_EMPTY = 2'd0,
    MARK_USED  = 2'd1,
    MARK_GONE  = 2'd2
  } mark_t;

  typedef enum logic [1:0] {
    WR_CLEAR,
    WR_ADD,
    WR_REMOVE
  } wsel_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_INIT,
    S_ISSUE,
    S_CHECK,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic    load_in;
    logic    mod_step;
    logic    probe_init;
    logic    probe_adv;
    logic    rd_en;
    logic    wr_en;
    wsel_t   wr_sel;
    logic    note_gone;
    logic    clr_step;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    res_load;
    status_t res_code;
  } cmd_t;

  typedef struct packed {
    logic  clr_last;
    logic  mod_last;
    logic  probe_last;
    mark_t mark;
    logic  key_match;
    logic  have_gone;
    op_t   op;
    logic  out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/qph_if.sv =====
// ----------------------------------------------------------------------------
// qph_if: request and response channels of the hash multimap
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface qph_req_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [qph_pkg::KEY_W-1:0]  key;
  logic [qph_pkg::VALUE_W-1:0] item_value;

  modport source (output valid, output operation, output key, output item_value,
                  input ready);
  modport sink   (input valid, input operation, input key, input item_value,
                  output ready);
endinterface

interface qph_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [qph_pkg::STATUS_W-1:0]      status;
  logic [qph_pkg::ENTRY_COUNT_W-1:0] entry_count;
  logic                              is_empty;

  modport source (output valid, output status, output entry_count, output is_empty,
                  input ready);
  modport sink   (input valid, input status, input entry_count, input is_empty,
                  output ready);
endinterface

`default_nettype wire

// ===== design/qph_ram.sv =====
// ----------------------------------------------------------------------------
// qph_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module qph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/qph_ctrl.sv =====
// ----------------------------------------------------------------------------
// qph_ctrl: operation sequencer
// Runs the clearing pass, the home slot reduction and the probe walk, and
// decides the outcome of each operation from the datapath status.
// ----------------------------------------------------------------------------
`default_nettype none

module qph_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire qph_pkg::sts_t sts,
  output qph_pkg::cmd_t      cmd
);
  import qph_pkg::*;

  state_t  state, state_next;
  status_t pend, pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      pend  <= RES_ADDED;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

  always_comb begin
    state_next = state;
    pend_next  = pend;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.wr_sel   = WR_CLEAR;
    cmd.res_code = pend;

    case (state)
      S_CLEAR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_sel   = WR_CLEAR;
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.probe_init = 1'b1;
        state_next     = S_ISSUE;
      end
      S_ISSUE: begin
        cmd.rd_en  = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.op == OP_ADD) begin
          if (sts.mark == MARK_EMPTY) begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_ADD;
            cmd.cnt_inc = 1'b1;
            pend_next   = RES_ADDED;
            state_next  = S_FINISH;
          end else if (sts.mark == MARK_USED && sts.key_match) begin
            pend_next  = RES_PRESENT;
            state_next = S_FINISH;
          end else begin
            cmd.note_gone = (sts.mark != MARK_USED) && !sts.have_gone;
            if (sts.probe_last) begin
              // Out of probes: reuse a deleted slot if one was seen.
              if (sts.have_gone || sts.mark != MARK_USED) begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WR_ADD;
                cmd.cnt_inc = 1'b1;
                pend_next   = RES_ADDED;
              end else begin
                pend_next = RES_FULL;
              end
              state_next = S_FINISH;
            end else begin
              cmd.probe_adv = 1'b1;
              state_next    = S_ISSUE;
            end
          end
        end else begin
          if (sts.mark == MARK_EMPTY) begin
            pend_next  = RES_NOTFOUND;
            state_next = S_FINISH;
          end else if (sts.mark == MARK_USED && sts.key_match) begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_REMOVE;
            cmd.cnt_dec = 1'b1;
            pend_next   = RES_REMOVED;
            state_next  = S_FINISH;
          end else if (sts.probe_last) begin
            pend_next  = RES_NOTFOUND;
            state_next = S_FINISH;
          end else begin
            cmd.probe_adv = 1'b1;
            state_next    = S_ISSUE;
          end
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/qph_dp.sv =====
// ----------------------------------------------------------------------------
// qph_dp: hash table datapath
// Input registers, home slot reduction, quadratic probe address generation,
// slot memory, pair counter and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module qph_dp #(
  parameter int CAPACITY = qph_pkg::CAPACITY_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         operation,
  input  wire logic [qph_pkg::KEY_W-1:0]    key,
  input  wire logic [qph_pkg::VALUE_W-1:0]  item_value,
  input  wire qph_pkg::cmd_t                cmd,
  output qph_pkg::sts_t                     sts,
  qph_rsp_if.source                         rsp
);
  import qph_pkg::*;

  localparam int SW     = $clog2(CAPACITY);
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int WORD_W = MARK_W + KEY_W + VALUE_W;
  localparam logic [SW:0]   CAP_X  = (SW + 1)'(CAPACITY);
  localparam logic [SW-1:0] LAST_I = SW'(CAPACITY - 1);

  // Operation registers
  op_t                op_r;
  logic [KEY_W-1:0]   key_r;
  logic [VALUE_W-1:0] val_r;

  // Home slot reduction
  logic [KEY_W-1:0]     mag;
  logic [SW-1:0]        rem, rem_next;
  logic [MOD_CNT_W-1:0] mod_cnt;
  logic [SW:0]          mod_t;

  // Probe walk
  logic [SW-1:0] slot, odd, idx, gone_at;
  logic          have_gone;
  logic [SW:0]   slot_sum, odd_sum, slot_red, odd_red;
  logic [SW-1:0] slot_adv, odd_adv;

  // Clearing pass and counters
  logic [SW-1:0] clr;
  logic [CW-1:0] count;
  logic [CW+ENTRY_COUNT_W-1:0] count_ext;

  // Memory
  logic              wr_en;
  logic [SW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data, rd_data;
  logic [MARK_W-1:0] rd_mark;
  logic [KEY_W-1:0]  rd_key;
  logic [VALUE_W-1:0] rd_val;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= op_t'(operation);
      key_r <= key;
      val_r <= item_value;
      mag   <= key[KEY_W-1] ? (~key + KEY_W'(1)) : key;
    end else if (cmd.mod_step) begin
      mag <= mag << MOD_BITS;
    end
  end

  // Remainder by the capacity, MOD_BITS key bits per cycle.
  always_comb begin
    rem_next = rem;
    mod_t    = '0;
    for (int j = 0; j < MOD_BITS; j++) begin
      mod_t = {rem_next, mag[KEY_W-1-j]};
      if (mod_t >= CAP_X) begin
        mod_t = mod_t - CAP_X;
      end
      rem_next = mod_t[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      rem     <= '0;
      mod_cnt <= '0;
    end else if (cmd.mod_step) begin
      rem     <= rem_next;
      mod_cnt <= mod_cnt + MOD_CNT_W'(1);
    end
  end

  // Successive squares differ by consecutive odd numbers.
  always_comb begin
    slot_sum = {1'b0, slot} + {1'b0, odd};
    slot_red = (slot_sum >= CAP_X) ? (slot_sum - CAP_X) : slot_sum;
    slot_adv = slot_red[SW-1:0];
    odd_sum  = {1'b0, odd} + (SW + 1)'(2);
    odd_red  = (odd_sum >= CAP_X) ? (odd_sum - CAP_X) : odd_sum;
    odd_adv  = odd_red[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.probe_init) begin
      slot <= rem;
      odd  <= SW'(1);
      idx  <= '0;
    end else if (cmd.probe_adv) begin
      slot <= slot_adv;
      odd  <= odd_adv;
      idx  <= idx + SW'(1);
    end
    if (cmd.note_gone) begin
      gone_at <= slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_gone <= 1'b0;
      clr       <= '0;
      count     <= '0;
    end else begin
      if (cmd.probe_init) begin
        have_gone <= 1'b0;
      end else if (cmd.note_gone) begin
        have_gone <= 1'b1;
      end
      if (cmd.clr_step) begin
        clr <= clr + SW'(1);
      end
      if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CW'(1);
      end
    end
  end

  always_comb begin
    wr_en = cmd.wr_en;
    case (cmd.wr_sel)
      WR_CLEAR: begin
        wr_addr = clr;
        wr_data = {MARK_EMPTY, key_r, val_r};
      end
      WR_ADD: begin
        wr_addr = have_gone ? gone_at : slot;
        wr_data = {MARK_USED, key_r, val_r};
      end
      WR_REMOVE: begin
        wr_addr = slot;
        wr_data = {MARK_GONE, key_r, val_r};
      end
      default: begin
        wr_addr = slot;
        wr_data = {MARK_EMPTY, key_r, val_r};
      end
    endcase
  end

  qph_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (slot),
    .rd_data (rd_data)
  );

  assign {rd_mark, rd_key, rd_val} = rd_data;

  // Result register
  assign count_ext = {{ENTRY_COUNT_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.res_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      rsp.status      <= cmd.res_code;
      rsp.entry_count <= count_ext[ENTRY_COUNT_W-1:0];
      rsp.is_empty    <= (count == '0);
    end
  end

  always_comb begin
    sts.clr_last   = (clr == LAST_I);
    sts.mod_last   = (mod_cnt == MOD_CNT_W'(MOD_STEPS - 1));
    sts.probe_last = (idx == LAST_I);
    sts.mark       = mark_t'(rd_mark);
    sts.key_match  = (rd_key == key_r) && (rd_val == val_r);
    sts.have_gone  = have_gone;
    sts.op         = op_r;
    sts.out_free   = !rsp.valid || rsp.ready;
  end

endmodule

`default_nettype wire

// ===== design/quadratic_probe_hash_multimap.sv =====
// Flow: a request beat has its key magnitude reduced to a home slot, then P
// probes are walked (P is 1 up to CAPACITY); each probe is one memory read
// plus a step to inspect the slot. The next request is taken in the cycle
// after the result is loaded, so operations are served one at a time.
// Reset: synchronous, active high; a clearing pass marks every slot empty
// before the first request is accepted.
// ----------------------------------------------------------------------------
// quadratic_probe_hash_multimap: open-addressing key/value multimap
// Top level joining the sequencer, the datapath and the channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_probe_hash_multimap #(
  parameter int CAPACITY = qph_pkg::CAPACITY_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  qph_req_if.sink   req,
  qph_rsp_if.source rsp
);
  import qph_pkg::*;

  // Command and status groups between the sequencer and the datapath.
  cmd_t cmd;
  sts_t sts;

  // The sequencer owns the request handshake: a request beat is taken only
  // while it waits in its idle state. Each beat starts one operation: the
  // key magnitude is reduced to a home slot, then slots home + i*i (mod
  // CAPACITY) are read one at a time until the outcome is known.
  qph_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the slot memory (mark, key and value per slot), the
  // pair counter and the result register. The result register separates the
  // response side; the sequencer loads a finished result only while that
  // register is empty or its beat is being taken, then returns to idle.
  qph_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .operation  (req.operation),
    .key        (req.key),
    .item_value (req.item_value),
    .cmd        (cmd),
    .sts        (sts),
    .rsp        (rsp)
  );

endmodule

`default_nettype wire

// ===== dv/quadratic_probe_hash_multimap_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quadratic_probe_hash_multimap_tb: self-checking bench for the hash multimap
// Drives add and remove requests over the request channel and predicts every
// response with a behavioral copy of the table: quadratic probe chains,
// deleted marks, slot reuse, the probe limit and the full condition. Each
// response beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module quadratic_probe_hash_multimap_tb;
  import qph_pkg::*;

  localparam int CAPACITY = CAPACITY_DEF;
  // Worst case latency of one operation: a walk of every probe plus overhead.
  localparam int OP_LATENCY = 7 + 2 * CAPACITY;
  // Generous bound on the whole run; the slowest legal run is far shorter.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_LIMIT = 20 * OP_LATENCY;
  // Length of the deliberate response stall in the backpressure test.
  localparam int HOLD_LEN = 300;

  localparam logic [KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;
  localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0001;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7fff_ffff;
  localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;

  // One predicted response beat.
  typedef struct packed {
    status_t                  status;
    logic [ENTRY_COUNT_W-1:0] count;
    logic                     is_empty;
  } map_result_t;

  logic clk = 1'b0;
  logic rst;

  qph_req_if req_ch ();
  qph_rsp_if rsp_ch ();

  quadratic_probe_hash_multimap #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the table. Keys and values are only looked at in slots
  // that are marked used, exactly like the block itself.
  logic [KEY_W-1:0]   map_key  [CAPACITY];
  logic [VALUE_W-1:0] map_val  [CAPACITY];
  mark_t              map_mark [CAPACITY];
  int                 pair_total;

  map_result_t map_results_q[$];

  int  err_cnt      = 0;
  int  sent_total   = 0;
  int  rsp_total    = 0;
  int  status_seen  [5];
  int  cycle_cnt    = 0;
  bit  src_idle_on  = 1'b1;
  bit  sink_idle_on = 1'b1;
  bit  hold_request = 1'b0;

  // --------------------------------------------------------------------------
  // Prediction. Applies one operation to the shadow table and returns the
  // status the block must report. The home slot comes from the key's
  // magnitude; probe i lands on home + i*i, wrapped to the capacity.
  // --------------------------------------------------------------------------
  function automatic status_t hash_update(op_t op, logic [KEY_W-1:0] k,
                                          logic [VALUE_W-1:0] v);
    logic [KEY_W-1:0] mag;
    int home;
    int slot;
    int gone_slot;
    int empty_slot;
    mag        = k[KEY_W-1] ? -k : k;
    home       = int'(mag % 32'(CAPACITY));
    gone_slot  = -1;
    empty_slot = -1;
    for (int i = 0; i < CAPACITY; i++) begin
      slot = (home + (i * i) % CAPACITY) % CAPACITY;
      if (op == OP_ADD) begin
        // An add stops at the first empty slot or at the identical pair,
        // remembering the first deleted slot it walked over.
        if (map_mark[slot] == MARK_EMPTY) begin
          empty_slot = slot;
          break;
        end
        if (map_mark[slot] == MARK_USED) begin
          if (map_key[slot] == k && map_val[slot] == v) return RES_PRESENT;
        end else if (gone_slot < 0) begin
          gone_slot = slot;
        end
      end else begin
        // A remove gives up at the first empty slot; deleted slots keep the
        // chain alive so it walks on past them.
        if (map_mark[slot] == MARK_EMPTY) return RES_NOTFOUND;
        if (map_mark[slot] == MARK_USED && map_key[slot] == k && map_val[slot] == v) begin
          map_mark[slot] = MARK_GONE;
          pair_total--;
          return RES_REMOVED;
        end
      end
    end
    // A remove that ran out of probes found nothing.
    if (op == OP_REMOVE) return RES_NOTFOUND;
    // Reuse the first deleted slot, else the empty one. Without either the
    // probe sequence is exhausted and the table counts as full, even when
    // slots the sequence never visits are free.
    slot = (gone_slot >= 0) ? gone_slot : empty_slot;
    if (slot < 0) return RES_FULL;
    map_key[slot]  = k;
    map_val[slot]  = v;
    map_mark[slot] = MARK_USED;
    pair_total++;
    return RES_ADDED;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver. Called just after a falling edge. It may idle for a few
  // cycles, then presents the beat and holds it until the block takes it at a
  // rising edge. The prediction is made at that edge, so predictions stay in
  // the order the block serves them. It returns at the next falling edge with
  // valid still high, so a following call never lowers and raises valid in
  // the same step.
  // --------------------------------------------------------------------------
  task automatic send_op(input op_t op, input logic [KEY_W-1:0] k,
                         input logic [VALUE_W-1:0] v);
    map_result_t want;
    while (src_idle_on && $urandom_range(99) < 27) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.operation  <= op;
    req_ch.key        <= k;
    req_ch.item_value <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    want.status   = hash_update(op, k, v);
    want.count    = ENTRY_COUNT_W'(pair_total);
    want.is_empty = (pair_total == 0);
    map_results_q.push_back(want);
    sent_total++;
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Mixed traffic. Most beats use keys from a few clustered home slots and a
  // handful of values, so chains collide, pairs repeat, deleted marks pile up
  // and the full condition comes around. Many removes target a pair that is
  // really held. The rest is noise: full-width random keys and values.
  // --------------------------------------------------------------------------
  task automatic run_mixed_ops(input int n);
    op_t                op;
    logic [KEY_W-1:0]   k;
    logic [VALUE_W-1:0] v;
    logic [KEY_W-1:0]   mag;
    int                 start;
    int                 slot;
    bit                 picked;
    for (int n_done = 0; n_done < n; n_done++) begin
      op     = ($urandom_range(99) < 48) ? OP_ADD : OP_REMOVE;
      picked = 1'b0;
      if (op == OP_REMOVE && $urandom_range(99) < 60) begin
        // Pick a pair that is held right now, searching from a random slot.
        start = $urandom_range(CAPACITY - 1);
        for (int j = 0; j < CAPACITY && !picked; j++) begin
          slot = (start + j) % CAPACITY;
          if (map_mark[slot] == MARK_USED) begin
            k      = map_key[slot];
            v      = map_val[slot];
            picked = 1'b1;
          end
        end
      end
      if (!picked) begin
        if ($urandom_range(9) < 3) begin
          k = $urandom;
          // The most negative key lies outside the legal key range.
          if (k == 32'h8000_0000) k = KEY_MAX;
        end else begin
          mag = $urandom_range(7) * 8 + CAPACITY * $urandom_range(15);
          k   = $urandom_range(1) ? -mag : mag;
        end
        v = ($urandom_range(9) < 7) ? VALUE_W'($urandom_range(3)) : VALUE_W'($urandom);
      end
      send_op(op, k, v);
    end
  endtask

  // --------------------------------------------------------------------------
  // Test tasks.
  // --------------------------------------------------------------------------

  // Field extremes, repeats, chains through deleted slots, slot reuse, a full
  // probe sequence and a remove that runs out of probes.
  task automatic test_directed();
    logic [KEY_W-1:0] mag;
    // Remove from an empty table.
    send_op(OP_REMOVE, KEY_MAX, VALUE_MAX);
    // Extreme keys and values; both largest magnitudes share a home slot.
    send_op(OP_ADD, KEY_MAX, VALUE_MIN);
    send_op(OP_ADD, KEY_MAX, VALUE_MIN);
    send_op(OP_ADD, KEY_MIN, VALUE_MAX);
    // Same key with another value is a separate pair.
    send_op(OP_ADD, KEY_MAX, 32'd1);
    // Value that is not held: the walk ends on an empty slot.
    send_op(OP_REMOVE, KEY_MAX, 32'd2);
    // Remove the head of the chain, then a pair behind the deleted mark.
    send_op(OP_REMOVE, KEY_MAX, VALUE_MIN);
    send_op(OP_REMOVE, KEY_MIN, VALUE_MAX);
    // An add walks past both deleted slots and reuses the first one.
    send_op(OP_ADD, KEY_MAX, 32'd7);
    send_op(OP_ADD, '0, '0);
    // Fill every slot that home 5's probe sequence can reach.
    for (int j = 0; j < 12; j++) begin
      mag = 5 + CAPACITY * j;
      send_op(OP_ADD, j[0] ? -mag : mag, VALUE_W'(j));
    end
    send_op(OP_ADD, 5 + CAPACITY * 12, 32'd12);
    // A repeat is still found in the saturated chain.
    send_op(OP_ADD, 5 + CAPACITY * 2, 32'd2);
    // A missing pair with that home walks every probe and is not found.
    send_op(OP_REMOVE, 5 + CAPACITY * 20, 32'd0);
    // Free one slot of the chain; the pair that was refused now fits.
    mag = 5 + CAPACITY * 3;
    send_op(OP_REMOVE, -mag, 32'd3);
    send_op(OP_ADD, 5 + CAPACITY * 12, 32'd12);
  endtask

  // Random traffic with both sides idling at random.
  task automatic test_random_traffic(input int n);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    run_mixed_ops(n);
  endtask

  // A long stretch with no idling on either side.
  task automatic test_back_to_back(input int n);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    run_mixed_ops(n);
  endtask

  // The response side stalls for a long stretch while requests keep coming,
  // so the block fills up and has to stall its request side.
  task automatic test_backpressure(input int n);
    src_idle_on = 1'b0;
    @(posedge clk);
    hold_request = 1'b1;
    @(negedge clk);
    run_mixed_ops(n);
    src_idle_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Response side. Ready changes only at falling edges. A hold request from a
  // test is picked up here and counted down in this process.
  // --------------------------------------------------------------------------
  initial begin : rsp_driver
    int hold_cnt;
    hold_cnt = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_cnt     = HOLD_LEN;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= !(sink_idle_on && $urandom_range(99) < 27);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker. Every response beat taken at a rising edge is matched with the
  // oldest prediction; a beat with nothing predicted is an error by itself.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    map_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      rsp_total++;
      if (map_results_q.size() == 0) begin
        $error("unexpected response beat: status %0d, entry_count %0d",
               rsp_ch.status, rsp_ch.entry_count);
        err_cnt++;
      end else begin
        want = map_results_q.pop_front();
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
          err_cnt++;
        end
        if (rsp_ch.entry_count !== want.count) begin
          $error("entry_count: expected %0d, actual %0d", want.count, rsp_ch.entry_count);
          err_cnt++;
        end
        if (rsp_ch.is_empty !== want.is_empty) begin
          $error("is_empty: expected %0d, actual %0d", want.is_empty, rsp_ch.is_empty);
          err_cnt++;
        end
        status_seen[want.status]++;
      end
    end
  end

  // Watchdog: counts cycles and stops a run that hangs.
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("DONE: errors detected");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, tests in turn, drain, verdict.
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int waited;
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.operation  <= OP_ADD;
    req_ch.key        <= '0;
    req_ch.item_value <= '0;
    for (int s = 0; s < CAPACITY; s++) begin
      map_key[s]  = '0;
      map_val[s]  = '0;
      map_mark[s] = MARK_EMPTY;
    end
    pair_total = 0;
    for (int s = 0; s < 5; s++) status_seen[s] = 0;

    // Reset is held, then released at a falling edge; the block then runs its
    // clearing pass and only raises ready when that is done.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_traffic(400);
    test_back_to_back(300);
    test_backpressure(30);
    test_random_traffic(400);
    req_ch.valid <= 1'b0;

    // Wait for every predicted beat, then a little longer to catch strays.
    waited = 0;
    while (map_results_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (OP_LATENCY + 8) @(posedge clk);
    if (map_results_q.size() != 0) begin
      $error("%0d predicted responses never arrived", map_results_q.size());
      err_cnt++;
    end

    $display("Run covered %0d requests and %0d responses in %0d cycles.",
             sent_total, rsp_total, cycle_cnt);
    $display("Statuses: added %0d, present %0d, removed %0d, not found %0d, full %0d.",
             status_seen[RES_ADDED], status_seen[RES_PRESENT], status_seen[RES_REMOVED],
             status_seen[RES_NOTFOUND], status_seen[RES_FULL]);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
